// ===== hw/rtl/cmr_pkg.sv =====
// ----------------------------------------------------------------------------
// cmr_pkg
// Shared constants, result codes and controller/datapath interface types of
// the multi-frame reassembler.
// ----------------------------------------------------------------------------
package cmr_pkg;

	localparam int SLOT_BYTES   = 7;
	localparam int HEADER_BYTES = 3;

	typedef enum logic [2:0] {
		ST_PENDING = 3'd0,
		ST_LOST    = 3'd1,
		ST_BAD     = 3'd2,
		ST_BYTE    = 3'd3,
		ST_EMPTY   = 3'd4
	} result_status_t;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_FETCH = 3'b010,
		S_EMIT  = 3'b100
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic start_emit;
		logic out_free;
		logic row_end;
		logic msg_end;
	} dp_status_t;

	typedef struct packed {
		logic idle;
		logic fetch;
		logic emit;
		logic finish;
	} ctrl_cmd_t;

endpackage

// ===== hw/rtl/cmr_ram.sv =====
// ----------------------------------------------------------------------------
// cmr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cmr_ram #(
	parameter int WIDTH = 56,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/cmr_ctrl.sv =====
// ----------------------------------------------------------------------------
// cmr_ctrl
// Sequencer: idles for frames, then walks the store rows to deliver a
// completed message one byte per transfer.
// ----------------------------------------------------------------------------
module cmr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmr_pkg::dp_status_t   st,
	output cmr_pkg::ctrl_cmd_t    cmd
);

	cmr_pkg::ctrl_state_t state_q, state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		unique case (state_q)
			cmr_pkg::S_IDLE: begin
				cmd.idle = 1'b1;
				if (st.accept && st.start_emit) begin
					state_d = cmr_pkg::S_FETCH;
				end
			end
			cmr_pkg::S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = cmr_pkg::S_EMIT;
			end
			cmr_pkg::S_EMIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					if (st.msg_end) begin
						cmd.finish = 1'b1;
						state_d    = cmr_pkg::S_IDLE;
					end else if (st.row_end) begin
						state_d = cmr_pkg::S_FETCH;
					end
				end
			end
			default: begin
				state_d = cmr_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cmr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/cmr_dp.sv =====
// ----------------------------------------------------------------------------
// cmr_dp
// Datapath: frame decode, slot masks, header lengths, message store, byte
// read-out counters and the result register.
// ----------------------------------------------------------------------------
module cmr_dp #(
	parameter int STORE_BYTES = 56
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmr_pkg::ctrl_cmd_t  cmd,
	output cmr_pkg::dp_status_t st,
	input  logic                frame_valid,
	input  logic [28:0]         frame_id,
	input  logic [7:0]          slot_index,
	input  logic [7:0]          byte_one,
	input  logic [7:0]          byte_two,
	input  logic [7:0]          byte_three,
	input  logic [7:0]          byte_four,
	input  logic [7:0]          byte_five,
	input  logic [7:0]          byte_six,
	input  logic [7:0]          byte_seven,
	output logic                result_valid,
	input  logic                result_stall,
	output logic [2:0]          status,
	output logic                byte_kind,
	output logic [7:0]          data_byte,
	output logic [28:0]         source_id,
	output logic                busy_res,
	output logic                last
);

	localparam int SLOT_COUNT = STORE_BYTES / cmr_pkg::SLOT_BYTES;
	localparam int BODY_MAX   = STORE_BYTES - cmr_pkg::HEADER_BYTES;
	localparam int AW         = $clog2(SLOT_COUNT);
	localparam int RW         = $clog2(SLOT_COUNT + 1);
	localparam int LEN_W      = $clog2(BODY_MAX + 1);
	localparam int SAT_W      = (LEN_W > 8) ? LEN_W : 8;
	localparam int COL_W      = $clog2(cmr_pkg::SLOT_BYTES);
	localparam int ROW_W      = cmr_pkg::SLOT_BYTES * 8;

	logic [SLOT_COUNT-1:0] exp_q, rcv_q, exp_n, rcv_n, low_mask, slot_bit;
	logic [LEN_W-1:0]      tl_q, pl_q, tl_n, pl_n, tl_d, pl_d, total;
	logic [LEN_W-1:0]      k_q;
	logic [RW-1:0]         row_q;
	logic [COL_W-1:0]      col_q;
	logic [28:0]           id_q;
	logic [SAT_W-1:0]      b2_w, b3_w, body_w, tl_w, rem_w, pl_w;
	logic                  accept, lost, bad, slot0, complete;
	logic                  row_ok;
	logic [ROW_W-1:0]      rdata;
	logic [7:0]            emit_byte;

	logic                  out_valid_q;
	logic [2:0]            status_q;
	logic                  kind_q;
	logic [7:0]            data_q;
	logic [28:0]           src_q;
	logic                  busy_q;
	logic                  last_q;

	assign st.out_free = !out_valid_q || !result_stall;
	assign accept      = frame_valid && cmd.idle && st.out_free;
	assign st.accept   = accept;

	assign slot0 = (slot_index == 8'd0);
	assign lost  = !slot0 && (exp_q == '0);
	assign bad   = !lost && (slot_index >= 8'(SLOT_COUNT));

	assign b2_w   = SAT_W'(byte_two);
	assign b3_w   = SAT_W'(byte_three);
	assign body_w = SAT_W'(BODY_MAX);
	assign tl_w   = (b2_w > body_w) ? body_w : b2_w;
	assign rem_w  = body_w - tl_w;
	assign pl_w   = (b3_w > rem_w) ? rem_w : b3_w;
	assign tl_d   = LEN_W'(tl_w);
	assign pl_d   = LEN_W'(pl_w);

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			low_mask[i] = (byte_one > 8'(i));
			slot_bit[i] = (slot_index == 8'(i));
		end
	end

	assign exp_n    = slot0 ? (exp_q | low_mask) : exp_q;
	assign rcv_n    = rcv_q | slot_bit;
	assign tl_n     = slot0 ? tl_d : tl_q;
	assign pl_n     = slot0 ? pl_d : pl_q;
	assign complete = (exp_n != '0) && (exp_n == rcv_n);
	assign total    = tl_n + pl_n;

	assign st.start_emit = !lost && !bad && complete && (total != '0);
	assign st.row_end    = (col_q == COL_W'(cmr_pkg::SLOT_BYTES - 1));
	assign st.msg_end    = ({1'b0, k_q} + (LEN_W + 1)'(1)) == {1'b0, tl_q + pl_q};

	cmr_ram #(
		.WIDTH (ROW_W),
		.DEPTH (SLOT_COUNT)
	) u_store (
		.clk   (clk),
		.we    (accept && !lost && !bad),
		.waddr (slot_index[AW-1:0]),
		.wdata ({byte_seven, byte_six, byte_five, byte_four,
			byte_three, byte_two, byte_one}),
		.re    (cmd.fetch),
		.raddr (row_q[AW-1:0]),
		.rdata (rdata)
	);

	assign row_ok    = (row_q < RW'(SLOT_COUNT)) && rcv_q[row_q[AW-1:0]];
	assign emit_byte = row_ok ? rdata[col_q*8 +: 8] : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= '0;
			rcv_q <= '0;
			tl_q  <= '0;
			pl_q  <= '0;
			id_q  <= '0;
			k_q   <= '0;
			row_q <= '0;
			col_q <= '0;
		end else begin
			if (accept) begin
				if (lost) begin
					exp_q <= '0;
					rcv_q <= '0;
				end else if (!bad) begin
					id_q <= frame_id;
					tl_q <= tl_n;
					pl_q <= pl_n;
					if (complete) begin
						exp_q <= '0;
						rcv_q <= (total == '0) ? '0 : rcv_n;
					end else begin
						exp_q <= exp_n;
						rcv_q <= rcv_n;
					end
					k_q   <= '0;
					row_q <= '0;
					col_q <= COL_W'(cmr_pkg::HEADER_BYTES);
				end
			end
			if (cmd.emit) begin
				k_q <= k_q + LEN_W'(1);
				if (st.row_end) begin
					col_q <= '0;
					row_q <= row_q + RW'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
			if (cmd.finish) begin
				rcv_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (st.out_free) begin
			out_valid_q <= (accept && !st.start_emit) || cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q <= cmr_pkg::ST_BYTE;
			kind_q   <= (k_q >= tl_q);
			data_q   <= emit_byte;
			src_q    <= id_q;
			busy_q   <= 1'b0;
			last_q   <= st.msg_end;
		end else if (accept) begin
			kind_q <= 1'b0;
			data_q <= 8'd0;
			last_q <= 1'b1;
			priority if (lost) begin
				status_q <= cmr_pkg::ST_LOST;
				src_q    <= id_q;
				busy_q   <= 1'b0;
			end else if (bad) begin
				status_q <= cmr_pkg::ST_BAD;
				src_q    <= id_q;
				busy_q   <= 1'b1;
			end else if (complete) begin
				status_q <= cmr_pkg::ST_EMPTY;
				src_q    <= frame_id;
				busy_q   <= 1'b0;
			end else begin
				status_q <= cmr_pkg::ST_PENDING;
				src_q    <= frame_id;
				busy_q   <= (exp_n != '0);
			end
		end
	end

	assign result_valid = out_valid_q;
	assign status       = status_q;
	assign byte_kind    = kind_q;
	assign data_byte    = data_q;
	assign source_id    = src_q;
	assign busy_res     = busy_q;
	assign last         = last_q;

endmodule

// ===== hw/rtl/can_multiframe_reassembler_top.sv =====
// ----------------------------------------------------------------------------
// can_multiframe_reassembler_top
// Reassembles multi-frame CAN messages into topic and payload byte streams.
// ----------------------------------------------------------------------------
// A frame that does not start a message delivery gives one result. A frame
// that completes a message with N body bytes gives N results, one per cycle
// while result_stall is low, with one store row read before each 7-byte store
// row touched; the next frame is taken after the last byte transfer. The
// store is one RAM row per slot, read one row at a time; a row never written
// since the last completion or lost-start error reads as zero.
module can_multiframe_reassembler_top #(
	parameter int STORE_BYTES = 56
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        frame_valid,
	output logic        frame_stall,
	input  logic [28:0] frame_id,
	input  logic [7:0]  slot_index,
	input  logic [7:0]  byte_one,
	input  logic [7:0]  byte_two,
	input  logic [7:0]  byte_three,
	input  logic [7:0]  byte_four,
	input  logic [7:0]  byte_five,
	input  logic [7:0]  byte_six,
	input  logic [7:0]  byte_seven,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  status,
	output logic        byte_kind,
	output logic [7:0]  data_byte,
	output logic [28:0] source_id,
	output logic        busy_res,
	output logic        last
);

	cmr_pkg::ctrl_cmd_t  cmd;
	cmr_pkg::dp_status_t st;

	assign frame_stall = !(cmd.idle && st.out_free);

	cmr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	cmr_dp #(
		.STORE_BYTES (STORE_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.frame_valid  (frame_valid),
		.frame_id     (frame_id),
		.slot_index   (slot_index),
		.byte_one     (byte_one),
		.byte_two     (byte_two),
		.byte_three   (byte_three),
		.byte_four    (byte_four),
		.byte_five    (byte_five),
		.byte_six     (byte_six),
		.byte_seven   (byte_seven),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.byte_kind    (byte_kind),
		.data_byte    (data_byte),
		.source_id    (source_id),
		.busy_res     (busy_res),
		.last         (last)
	);

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		st.accept && !st.start_emit |=> result_valid && last)
		else $error("frame transfer gave no final result");

	a_emit_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fetch || cmd.emit) |-> frame_stall)
		else $error("frame taken during message delivery");

	a_byte_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == cmr_pkg::ST_BYTE) |-> !busy_res)
		else $error("delivered byte flagged busy");

	a_fetch_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fetch |=> !cmd.fetch && !cmd.idle)
		else $error("row fetch not followed by delivery");

endmodule
